### src/psa_pkg.sv
// ---------------------------------------------------------------------------
// psa_pkg: shared types and constants of the pedometer step accumulator
// Register indexes, reset values, configuration, state, input word and
// result word layouts used by the accumulator modules.
// ---------------------------------------------------------------------------
package psa_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STEPS_PER_MIN  = 3'd0,
    REG_GAP_MAX        = 3'd1,
    REG_REJECTS_DROP   = 3'd2,
    REG_STALE_LIMIT    = 3'd3,
    REG_FEATURE_ON     = 3'd4
  } psa_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Display status codes
  typedef enum logic [1:0] {
    DISP_HIDDEN  = 2'd0,
    DISP_STOPPED = 2'd1,
    DISP_LIVE    = 2'd2
  } psa_disp_e;

  // Reset values of the configuration registers
  localparam logic [15:0] RstStepsPerMin = 16'd250;
  localparam logic [15:0] RstGapMax      = 16'd60;
  localparam logic [7:0]  RstRejectsDrop = 8'd3;
  localparam logic [15:0] RstStaleLimit  = 16'd30;
  localparam logic        RstFeatureOn   = 1'b1;

  // Saturation limits
  localparam logic [7:0]  RejectRunMax = 8'hFF;
  localparam logic [31:0] CountMax     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] steps_per_minute_max;
    logic [15:0] credited_gap_max;
    logic [7:0]  rejections_before_drop;
    logic [15:0] stale_limit_minutes;
    logic        feature_on;
  } psa_cfg_t;

  typedef struct packed {
    logic        has_baseline;
    logic [31:0] baseline_count;
    logic [31:0] today_total;
    logic [31:0] yesterday_total;
    logic [7:0]  reject_run;
    logic        day_seen;
    logic [31:0] current_day;
    logic [31:0] minutes_unread;
  } psa_state_t;

  typedef struct packed {
    logic        got_reading;
    logic        expected_reading;
    logic [31:0] raw_count;
    logic [31:0] minutes_elapsed;
    logic [31:0] day_number;
    logic        clock_trusted;
    logic        sensor_failed;
  } psa_in_t;

  typedef struct packed {
    logic [31:0] steps_added;
    logic        restart_seen;
    logic        reading_rejected;
    logic        baseline_lost;
    logic        day_changed;
    logic [31:0] steps_today;
    logic [31:0] steps_yesterday;
    psa_disp_e   display_status;
  } psa_res_t;

endpackage

### src/psa_cfg_regs.sv
// ---------------------------------------------------------------------------
// psa_cfg_regs: configuration register file
// Holds the five configuration registers, written through a plain write port.
// ---------------------------------------------------------------------------
module psa_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [psa_pkg::CfgDataW-1:0]  cfg_data_i,
  output psa_pkg::psa_cfg_t             cfg_o
);
  import psa_pkg::*;

  psa_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_minute_max   <= RstStepsPerMin;
      cfg_q.credited_gap_max       <= RstGapMax;
      cfg_q.rejections_before_drop <= RstRejectsDrop;
      cfg_q.stale_limit_minutes    <= RstStaleLimit;
      cfg_q.feature_on             <= RstFeatureOn;
    end else if (cfg_we_i) begin
      // unknown indexes are dropped
      case (cfg_idx_i)
        REG_STEPS_PER_MIN: cfg_q.steps_per_minute_max   <= cfg_data_i;
        REG_GAP_MAX:       cfg_q.credited_gap_max       <= cfg_data_i;
        REG_REJECTS_DROP:  cfg_q.rejections_before_drop <= cfg_data_i[7:0];
        REG_STALE_LIMIT:   cfg_q.stale_limit_minutes    <= cfg_data_i;
        REG_FEATURE_ON:    cfg_q.feature_on             <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/psa_update.sv
// ---------------------------------------------------------------------------
// psa_update: single-pass state update
// Works out the next accumulator state and the result word for one wake.
// ---------------------------------------------------------------------------
module psa_update (
  input  psa_pkg::psa_cfg_t   cfg_i,
  input  psa_pkg::psa_state_t st_i,
  input  psa_pkg::psa_in_t    wake_i,
  output psa_pkg::psa_state_t st_o,
  output psa_pkg::psa_res_t   res_o
);
  import psa_pkg::*;

  logic        back;
  logic [31:0] delta;
  logic [31:0] mins_raw;
  logic [15:0] mins;
  logic [31:0] bound;
  logic        credit;
  logic [32:0] today_sum;
  logic [31:0] today_cred;
  logic [7:0]  run_inc;
  logic [32:0] unread_sum;

  always_comb begin
    back       = wake_i.raw_count < st_i.baseline_count;
    delta      = back ? wake_i.raw_count : wake_i.raw_count - st_i.baseline_count;
    mins_raw   = (wake_i.minutes_elapsed == 32'd0) ? 32'd1 : wake_i.minutes_elapsed;
    mins       = (mins_raw > {16'd0, cfg_i.credited_gap_max}) ? cfg_i.credited_gap_max
                                                               : mins_raw[15:0];
    bound      = {16'd0, mins} * {16'd0, cfg_i.steps_per_minute_max};
    credit     = delta <= bound;
    today_sum  = {1'b0, st_i.today_total} + {1'b0, delta};
    today_cred = today_sum[32] ? CountMax : today_sum[31:0];
    run_inc    = (st_i.reject_run == RejectRunMax) ? RejectRunMax : st_i.reject_run + 8'd1;
    unread_sum = {1'b0, st_i.minutes_unread} + {1'b0, wake_i.minutes_elapsed};

    st_o                   = st_i;
    res_o.steps_added      = 32'd0;
    res_o.restart_seen     = 1'b0;
    res_o.reading_rejected = 1'b0;
    res_o.baseline_lost    = 1'b0;
    res_o.day_changed      = 1'b0;

    if (wake_i.got_reading) begin
      if (!st_i.has_baseline) begin
        st_o.has_baseline   = 1'b1;
        st_o.baseline_count = wake_i.raw_count;
      end else if (credit) begin
        st_o.baseline_count = wake_i.raw_count;
        st_o.today_total    = today_cred;
        st_o.reject_run     = 8'd0;
        res_o.steps_added   = delta;
        res_o.restart_seen  = back;
      end else begin
        res_o.reading_rejected = 1'b1;
        st_o.reject_run        = run_inc;
        if (run_inc >= cfg_i.rejections_before_drop) begin
          st_o.has_baseline   = 1'b0;
          st_o.baseline_count = 32'd0;
          st_o.reject_run     = 8'd0;
          res_o.baseline_lost = 1'b1;
        end
      end
      if (wake_i.clock_trusted) begin
        if (!st_i.day_seen) begin
          st_o.day_seen    = 1'b1;
          st_o.current_day = wake_i.day_number;
        end else if (wake_i.day_number != st_i.current_day) begin
          st_o.yesterday_total = st_o.today_total;
          st_o.today_total     = 32'd0;
          st_o.current_day     = wake_i.day_number;
          res_o.day_changed    = 1'b1;
        end
      end
      st_o.minutes_unread = 32'd0;
    end else if (wake_i.expected_reading) begin
      st_o.minutes_unread = unread_sum[32] ? CountMax : unread_sum[31:0];
    end

    res_o.steps_today     = st_o.today_total;
    res_o.steps_yesterday = st_o.yesterday_total;

    if (!cfg_i.feature_on) begin
      res_o.display_status = DISP_HIDDEN;
    end else if (wake_i.sensor_failed || !st_o.has_baseline ||
                 st_o.minutes_unread >= {16'd0, cfg_i.stale_limit_minutes}) begin
      res_o.display_status = DISP_STOPPED;
    end else begin
      res_o.display_status = DISP_LIVE;
    end
  end

endmodule

### src/pedometer_step_accumulator.sv
// ---------------------------------------------------------------------------
// pedometer_step_accumulator: wake-event step accumulator
// Credits plausible sensor step deltas to a daily total, rolls days over and
// tracks how long the sensor has gone unread.
// ---------------------------------------------------------------------------
// One input word describes one wake; it yields exactly one result word. Words
// enter an input register, pass once through the update logic against the
// held state, and land in a result register; the block takes one word per
// cycle for as long as the result side keeps taking them. The limit on that
// rate is the state feedback through the combinational update logic
// (subtract, bound multiply, saturating adds). The input register frees
// itself whenever its word moves on, so a new word is taken while a finished
// result still waits to be taken.
// Configuration writes take effect at the next clock edge and should only be
// made while no word is in flight.
// ---------------------------------------------------------------------------
module pedometer_step_accumulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [psa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [psa_pkg::CfgDataW-1:0]  cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          got_reading_i,
  input  logic                          expected_reading_i,
  input  logic [31:0]                   raw_count_i,
  input  logic [31:0]                   minutes_elapsed_i,
  input  logic signed [31:0]            day_number_i,
  input  logic                          clock_trusted_i,
  input  logic                          sensor_failed_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   steps_added_o,
  output logic                          restart_seen_o,
  output logic                          reading_rejected_o,
  output logic                          baseline_lost_o,
  output logic                          day_changed_o,
  output logic [31:0]                   steps_today_o,
  output logic [31:0]                   steps_yesterday_o,
  output logic [1:0]                    display_status_o
);
  import psa_pkg::*;

  psa_cfg_t   cfg;
  psa_state_t st_q, st_d;
  psa_in_t    in_q;
  logic       in_vld_q;
  psa_res_t   res_d, res_q;
  logic       out_vld_q;
  logic       out_free;
  logic       advance;

  psa_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  psa_update u_update (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .wake_i (in_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // Advance the held word when the result register is empty or being emptied
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || advance;

  // Input register: capture a word on accept, drop it once it has moved on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.got_reading      <= got_reading_i;
      in_q.expected_reading <= expected_reading_i;
      in_q.raw_count        <= raw_count_i;
      in_q.minutes_elapsed  <= minutes_elapsed_i;
      in_q.day_number       <= $unsigned(day_number_i);
      in_q.clock_trusted    <= clock_trusted_i;
      in_q.sensor_failed    <= sensor_failed_i;
    end
  end

  // Accumulator state: commit the update as the word moves into the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign steps_added_o      = res_q.steps_added;
  assign restart_seen_o     = res_q.restart_seen;
  assign reading_rejected_o = res_q.reading_rejected;
  assign baseline_lost_o    = res_q.baseline_lost;
  assign day_changed_o      = res_q.day_changed;
  assign steps_today_o      = res_q.steps_today;
  assign steps_yesterday_o  = res_q.steps_yesterday;
  assign display_status_o   = res_q.display_status;

  // A dropped baseline only ever follows a rejected reading
  a_lost_needs_reject : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.baseline_lost |-> res_q.reading_rejected)
    else $error("baseline dropped without a rejection");

  // A rejected reading credits nothing and is no restart
  a_reject_no_credit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.reading_rejected |-> (res_q.steps_added == 32'd0) &&
                                             !res_q.restart_seen)
    else $error("rejected reading credited steps");

  // The waiting result matches the committed state: live needs a baseline
  a_live_has_base : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.display_status == DISP_LIVE) |-> st_q.has_baseline)
    else $error("live display without a baseline");

  // Shown totals track the committed state while the result waits
  a_totals_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.steps_today == st_q.today_total) &&
                  (res_q.steps_yesterday == st_q.yesterday_total))
    else $error("result totals differ from state");

endmodule

### bench/psa_result_checker.sv
// ---------------------------------------------------------------------------
// psa_result_checker: result predictor and comparator for the step accumulator
// Tracks configuration writes, predicts the result word of every accepted wake
// word and compares each accepted result word field by field, in order.
// ---------------------------------------------------------------------------
module psa_result_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [psa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [psa_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         got_reading_i,
  input  logic                         expected_reading_i,
  input  logic [31:0]                  raw_count_i,
  input  logic [31:0]                  minutes_elapsed_i,
  input  logic [31:0]                  day_number_i,
  input  logic                         clock_trusted_i,
  input  logic                         sensor_failed_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [31:0]                  steps_added_i,
  input  logic                         restart_seen_i,
  input  logic                         reading_rejected_i,
  input  logic                         baseline_lost_i,
  input  logic                         day_changed_i,
  input  logic [31:0]                  steps_today_i,
  input  logic [31:0]                  steps_yesterday_i,
  input  logic [1:0]                   display_status_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           restarts_o,
  output int                           rejects_o,
  output int                           drops_o,
  output int                           rollovers_o
);
  import psa_pkg::*;

  localparam int MaxShown = 40;

  // Configuration copy
  logic [15:0] c_spm;
  logic [15:0] c_gap;
  logic [7:0]  c_drop;
  logic [15:0] c_stale;
  logic        c_fe;

  // Accumulator state copy
  logic        base_valid;
  logic [31:0] base_count;
  logic [31:0] today_sum;
  logic [31:0] yday_sum;
  logic [7:0]  streak;
  logic        day_noted;
  logic [31:0] day_held;
  logic [31:0] unread_min;

  psa_res_t awaited_q[$];

  int mismatches;
  int waiting_n;
  int checked_n;
  int restart_n;
  int reject_n;
  int drop_n;
  int roll_n;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting_n;
  assign checked_o    = checked_n;
  assign restarts_o   = restart_n;
  assign rejects_o    = reject_n;
  assign drops_o      = drop_n;
  assign rollovers_o  = roll_n;

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? CountMax : s[31:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("[%0t] result %0d: %s is %h, expected %h", $time, checked_n, what, seen,
               wanted);
    end
  endtask

  // Work out the result word of one wake and advance the state copy.
  task automatic advance_tally(input psa_in_t w, output psa_res_t r);
    logic        back;
    logic [31:0] delta;
    logic [31:0] m;
    logic [31:0] bound;
    r = '0;
    if (w.got_reading) begin
      if (!base_valid) begin
        base_valid = 1'b1;
        base_count = w.raw_count;
      end else begin
        back  = w.raw_count < base_count;
        delta = back ? w.raw_count : w.raw_count - base_count;
        m     = (w.minutes_elapsed == 32'd0) ? 32'd1 : w.minutes_elapsed;
        if (m > {16'd0, c_gap}) m = {16'd0, c_gap};
        bound = m * {16'd0, c_spm};
        if (delta <= bound) begin
          base_count     = w.raw_count;
          today_sum      = sat_sum(today_sum, delta);
          streak         = '0;
          r.steps_added  = delta;
          r.restart_seen = back;
        end else begin
          r.reading_rejected = 1'b1;
          if (streak != RejectRunMax) streak++;
          if (streak >= c_drop) begin
            base_valid      = 1'b0;
            base_count      = '0;
            streak          = '0;
            r.baseline_lost = 1'b1;
          end
        end
      end
      if (w.clock_trusted) begin
        if (!day_noted) begin
          day_held  = w.day_number;
          day_noted = 1'b1;
        end else if (w.day_number != day_held) begin
          yday_sum      = today_sum;
          today_sum     = '0;
          day_held      = w.day_number;
          r.day_changed = 1'b1;
        end
      end
      unread_min = '0;
    end else if (w.expected_reading) begin
      unread_min = sat_sum(unread_min, w.minutes_elapsed);
    end

    if (!c_fe) begin
      r.display_status = DISP_HIDDEN;
    end else if (w.sensor_failed || !base_valid || unread_min >= {16'd0, c_stale}) begin
      r.display_status = DISP_STOPPED;
    end else begin
      r.display_status = DISP_LIVE;
    end
    r.steps_today     = today_sum;
    r.steps_yesterday = yday_sum;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    psa_in_t  w;
    psa_res_t want;
    if (!rst_ni) begin
      c_spm      = RstStepsPerMin;
      c_gap      = RstGapMax;
      c_drop     = RstRejectsDrop;
      c_stale    = RstStaleLimit;
      c_fe       = RstFeatureOn;
      base_valid = 1'b0;
      base_count = '0;
      today_sum  = '0;
      yday_sum   = '0;
      streak     = '0;
      day_noted  = 1'b0;
      day_held   = '0;
      unread_min = '0;
      awaited_q.delete();
      waiting_n  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEPS_PER_MIN: c_spm   = cfg_data_i;
          REG_GAP_MAX:       c_gap   = cfg_data_i;
          REG_REJECTS_DROP:  c_drop  = cfg_data_i[7:0];
          REG_STALE_LIMIT:   c_stale = cfg_data_i;
          REG_FEATURE_ON:    c_fe    = cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        w.got_reading      = got_reading_i;
        w.expected_reading = expected_reading_i;
        w.raw_count        = raw_count_i;
        w.minutes_elapsed  = minutes_elapsed_i;
        w.day_number       = day_number_i;
        w.clock_trusted    = clock_trusted_i;
        w.sensor_failed    = sensor_failed_i;
        advance_tally(w, want);
        awaited_q.push_back(want);
        if (want.restart_seen) restart_n++;
        if (want.reading_rejected) reject_n++;
        if (want.baseline_lost) drop_n++;
        if (want.day_changed) roll_n++;
      end

      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("unexpected result, steps_today", steps_today_i, '0);
        end else begin
          want = awaited_q.pop_front();
          if (steps_added_i !== want.steps_added)
            report_mismatch("steps_added", steps_added_i, want.steps_added);
          if (restart_seen_i !== want.restart_seen)
            report_mismatch("restart_seen", 32'(restart_seen_i), 32'(want.restart_seen));
          if (reading_rejected_i !== want.reading_rejected)
            report_mismatch("reading_rejected", 32'(reading_rejected_i),
                            32'(want.reading_rejected));
          if (baseline_lost_i !== want.baseline_lost)
            report_mismatch("baseline_lost", 32'(baseline_lost_i), 32'(want.baseline_lost));
          if (day_changed_i !== want.day_changed)
            report_mismatch("day_changed", 32'(day_changed_i), 32'(want.day_changed));
          if (steps_today_i !== want.steps_today)
            report_mismatch("steps_today", steps_today_i, want.steps_today);
          if (steps_yesterday_i !== want.steps_yesterday)
            report_mismatch("steps_yesterday", steps_yesterday_i, want.steps_yesterday);
          if (display_status_i !== want.display_status)
            report_mismatch("display_status", 32'(display_status_i),
                            32'(want.display_status));
        end
        checked_n++;
      end
      waiting_n = awaited_q.size();
    end
  end

endmodule

### bench/pedometer_step_accumulator_tb.sv
// ---------------------------------------------------------------------------
// pedometer_step_accumulator_tb: self-checking bench of the step accumulator
// Drives a directed run of wake words through the reset settings, then random
// phases of mostly well-formed sensor sequences under several register
// settings and back-pressure patterns; a side checker predicts every result.
// ---------------------------------------------------------------------------
module pedometer_step_accumulator_tb;
  import psa_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int NumPhases     = 6;
  localparam int WordsPerPhase = 66;
  localparam int SettleCycles  = 4;
  localparam int DrainCycles   = 8;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                got_reading_i;
  logic                expected_reading_i;
  logic [31:0]         raw_count_i;
  logic [31:0]         minutes_elapsed_i;
  logic signed [31:0]  day_number_i;
  logic                clock_trusted_i;
  logic                sensor_failed_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [31:0]         steps_added_o;
  logic                restart_seen_o;
  logic                reading_rejected_o;
  logic                baseline_lost_o;
  logic                day_changed_o;
  logic [31:0]         steps_today_o;
  logic [31:0]         steps_yesterday_o;
  logic [1:0]          display_status_o;

  int fail_count;
  int pending;
  int checked;
  int restarts;
  int rejects;
  int drops;
  int rollovers;

  // Idle rates in percent, per side
  int tx_idle_pct;
  int rx_idle_pct;

  // Sensor model used to shape the stimulus (not for checking)
  logic [31:0] prev_count;
  logic [31:0] day_now;
  logic [15:0] spm_set;
  logic [15:0] gap_set;
  int          settings_done;
  int          stall_cycles;

  pedometer_step_accumulator u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .got_reading_i      (got_reading_i),
    .expected_reading_i (expected_reading_i),
    .raw_count_i        (raw_count_i),
    .minutes_elapsed_i  (minutes_elapsed_i),
    .day_number_i       (day_number_i),
    .clock_trusted_i    (clock_trusted_i),
    .sensor_failed_i    (sensor_failed_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .steps_added_o      (steps_added_o),
    .restart_seen_o     (restart_seen_o),
    .reading_rejected_o (reading_rejected_o),
    .baseline_lost_o    (baseline_lost_o),
    .day_changed_o      (day_changed_o),
    .steps_today_o      (steps_today_o),
    .steps_yesterday_o  (steps_yesterday_o),
    .display_status_o   (display_status_o)
  );

  psa_result_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .got_reading_i      (got_reading_i),
    .expected_reading_i (expected_reading_i),
    .raw_count_i        (raw_count_i),
    .minutes_elapsed_i  (minutes_elapsed_i),
    .day_number_i       (day_number_i),
    .clock_trusted_i    (clock_trusted_i),
    .sensor_failed_i    (sensor_failed_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .steps_added_i      (steps_added_o),
    .restart_seen_i     (restart_seen_o),
    .reading_rejected_i (reading_rejected_o),
    .baseline_lost_i    (baseline_lost_o),
    .day_changed_i      (day_changed_o),
    .steps_today_i      (steps_today_o),
    .steps_yesterday_i  (steps_yesterday_o),
    .display_status_i   (display_status_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked),
    .restarts_o         (restarts),
    .rejects_o          (rejects),
    .drops_o            (drops),
    .rollovers_o        (rollovers)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: roll the stall dice on every falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic psa_in_t wake(input logic got, input logic exp_rd,
                                   input logic [31:0] raw, input logic [31:0] mins,
                                   input logic [31:0] day, input logic trusted,
                                   input logic failed);
    psa_in_t w;
    w.got_reading      = got;
    w.expected_reading = exp_rd;
    w.raw_count        = raw;
    w.minutes_elapsed  = mins;
    w.day_number       = day;
    w.clock_trusted    = trusted;
    w.sensor_failed    = failed;
    return w;
  endfunction

  // Offer one wake word; idle first at the sender's rate, then hold valid and
  // the payload until the word is taken. Enter and leave on a falling edge.
  task automatic send_wake(input psa_in_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    got_reading_i      <= w.got_reading;
    expected_reading_i <= w.expected_reading;
    raw_count_i        <= w.raw_count;
    minutes_elapsed_i  <= w.minutes_elapsed;
    day_number_i       <= w.day_number;
    clock_trusted_i    <= w.clock_trusted;
    sensor_failed_i    <= w.sensor_failed;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every result to come back, then let the pipe empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write all five registers on consecutive edges; keep a copy of the bound
  // registers so the stimulus can aim around the plausibility limit.
  task automatic apply_settings(input logic [15:0] spm, input logic [15:0] gap,
                                input logic [15:0] drop, input logic [15:0] stale,
                                input logic [15:0] fe);
    psa_reg_e    regs[5] = '{REG_STEPS_PER_MIN, REG_GAP_MAX, REG_REJECTS_DROP,
                             REG_STALE_LIMIT, REG_FEATURE_ON};
    logic [15:0] vals[5];
    vals = '{spm, gap, drop, stale, fe};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    spm_set  = spm;
    gap_set  = gap;
    settings_done++;
  endtask

  // Draw one random wake: mostly plausible readings that keep the baseline
  // alive, with restarts, implausible jumps, missed wakes and raw noise mixed in.
  task automatic make_wake(output psa_in_t w);
    int          kind;
    int          dayroll;
    logic [31:0] m;
    logic [31:0] lim;
    kind    = $urandom_range(99);
    dayroll = $urandom_range(99);
    if (dayroll < 6) day_now = day_now + 32'd1;
    else if (dayroll < 8) day_now = $urandom;

    w = wake(1'b1, 1'($urandom_range(1)), prev_count, '0, day_now,
             ($urandom_range(9) != 0), ($urandom_range(19) == 0));
    w.minutes_elapsed = ($urandom_range(3) == 0) ? $urandom
                                                 : $urandom_range(0, 2 * gap_set);
    m = (w.minutes_elapsed == 32'd0) ? 32'd1 : w.minutes_elapsed;
    if (m > {16'd0, gap_set}) m = {16'd0, gap_set};
    lim = m * {16'd0, spm_set};

    if (kind < 50) begin
      w.raw_count = prev_count + $urandom_range(0, lim);
    end else if (kind < 60) begin
      w.raw_count = $urandom_range(0, prev_count);
    end else if (kind < 70) begin
      w.raw_count = prev_count + lim + 32'd1 + $urandom_range(0, 1 << 20);
    end else if (kind < 85) begin
      w.got_reading     = 1'b0;
      w.raw_count       = $urandom;
      w.minutes_elapsed = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 40);
    end else begin
      w = wake(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom, $urandom,
               1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    if (w.got_reading) prev_count = w.raw_count;
  endtask

  initial begin
    psa_in_t w;
    psa_in_t directed_q[$];

    // Hold every input at a known value from time zero.
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_STEPS_PER_MIN;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    got_reading_i      = 1'b0;
    expected_reading_i = 1'b0;
    raw_count_i        = '0;
    minutes_elapsed_i  = '0;
    day_number_i       = '0;
    clock_trusted_i    = 1'b0;
    sensor_failed_i    = 1'b0;
    out_ready_i        = 1'b0;
    tx_idle_pct        = 27;
    rx_idle_pct        = 82;
    stall_cycles       = 0;
    settings_done      = 0;
    spm_set            = RstStepsPerMin;
    gap_set            = RstGapMax;
    prev_count         = '0;
    day_now            = 32'd200;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed run under the reset settings (bound 250 per minute, clamp 60,
    // drop after 3, stale at 30 minutes).
    // missed expected wake before any baseline: display stopped
    directed_q.push_back(wake(1'b0, 1'b1, 32'd0, 32'd10, 32'd0, 1'b0, 1'b0));
    // first reading only sets the baseline and records the day
    directed_q.push_back(wake(1'b1, 1'b0, 32'd1000, 32'd5, 32'd100, 1'b1, 1'b0));
    // zero minutes count as one: delta exactly at the bound is credited
    directed_q.push_back(wake(1'b1, 1'b1, 32'd1250, 32'd0, 32'd100, 1'b1, 1'b0));
    // one step over the bound is rejected
    directed_q.push_back(wake(1'b1, 1'b1, 32'd1501, 32'd1, 32'd100, 1'b1, 1'b0));
    // huge gap clamped to the maximum: exactly at the clamped bound
    directed_q.push_back(wake(1'b1, 1'b1, 32'd16250, 32'hFFFF_FFFF, 32'd100, 1'b1, 1'b0));
    // counter went backwards: whole count is new steps
    directed_q.push_back(wake(1'b1, 1'b1, 32'd5, 32'd3, 32'd100, 1'b1, 1'b0));
    // new day with a trusted clock rolls today into yesterday
    directed_q.push_back(wake(1'b1, 1'b1, 32'd5, 32'd1, 32'd101, 1'b1, 1'b0));
    // untrusted clock: day change ignored
    directed_q.push_back(wake(1'b1, 1'b1, 32'd5, 32'd1, 32'd500, 1'b0, 1'b0));
    // three implausible jumps in a row: the last drops the baseline
    repeat (3) directed_q.push_back(wake(1'b1, 1'b1, 32'hF000_0000, 32'd1, 32'd101,
                                         1'b1, 1'b0));
    // fresh baseline at zero
    directed_q.push_back(wake(1'b1, 1'b1, 32'd0, 32'd1, 32'd101, 1'b1, 1'b0));
    // unexpected missed wake leaves the unread minutes alone
    directed_q.push_back(wake(1'b0, 1'b0, 32'hFFFF_FFFF, 32'd100, 32'd101, 1'b1, 1'b0));
    // unread minutes just below, then at the stale limit, then saturating
    directed_q.push_back(wake(1'b0, 1'b1, 32'd0, 32'd29, 32'd101, 1'b1, 1'b0));
    directed_q.push_back(wake(1'b0, 1'b1, 32'd0, 32'd1, 32'd101, 1'b1, 1'b0));
    directed_q.push_back(wake(1'b0, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd101, 1'b1, 1'b0));
    directed_q.push_back(wake(1'b0, 1'b1, 32'd0, 32'd5, 32'd101, 1'b1, 1'b0));
    // reading clears the unread minutes; failed sensor still shows stopped
    directed_q.push_back(wake(1'b1, 1'b1, 32'd0, 32'd0, 32'd101, 1'b1, 1'b1));
    // all-ones count rejected, day jumps to the most negative value
    directed_q.push_back(wake(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                              1'b1, 1'b0));
    // credit and roll to the most positive day, then same day again
    directed_q.push_back(wake(1'b1, 1'b1, 32'd100, 32'd1, 32'h7FFF_FFFF, 1'b1, 1'b0));
    directed_q.push_back(wake(1'b1, 1'b0, 32'd100, 32'd0, 32'h7FFF_FFFF, 1'b1, 1'b0));
    foreach (directed_q[i]) send_wake(directed_q[i]);
    prev_count = 32'd100;

    // Random phases; each one reprograms the registers while nothing is in
    // flight and picks its back-pressure pattern.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: apply_settings(16'd1, 16'd1, 16'd1, 16'd0, 16'h0001);
        1: apply_settings(16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF, 16'h0001);
        2: apply_settings(16'd0, 16'd60, 16'hFF00, 16'd1, 16'hFFFE);
        3: apply_settings(16'd1000, 16'd10, 16'd2, 16'd100, 16'h0001);
        4: apply_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 200)),
                          16'($urandom_range(1, 255)), 16'($urandom_range(0, 300)),
                          16'h0001);
        default: apply_settings(RstStepsPerMin, RstGapMax, 16'(RstRejectsDrop),
                                RstStaleLimit, 16'(RstFeatureOn));
      endcase
      case (p % 3)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct = 82;
        end
        1: begin
          tx_idle_pct = 82;
          rx_idle_pct = 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      repeat (WordsPerPhase) begin
        make_wake(w);
        send_wake(w);
      end
    end

    // Drain: wait for the last results, then a few idle cycles.
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Checked %0d results across %0d register settings: %0d restarts, %0d rejected",
             checked, settings_done, restarts, rejects);
    $display("%0d baseline drops, %0d day rollovers, %0d mismatching fields", drops,
             rollovers, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
